[design/segment_queue_packetizer_defines.svh]
// assertion macros for the segment queue packetizer
`ifndef SEGMENT_QUEUE_PACKETIZER_DEFINES_SVH
`define SEGMENT_QUEUE_PACKETIZER_DEFINES_SVH

// checked only while out of reset
`define SQP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define SQP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[design/sqp_pkg.sv]
package sqp_pkg;

    localparam int RING_DEPTH_DEF   = 8;
    localparam int PACKET_BYTES_DEF = 64;

    localparam int TX_LEN_W = 7;
    localparam int PEND_W   = 3;

    localparam logic [6:0] EP_NUM_MASK = 7'h7F;
    localparam logic [6:0] EP_TX       = 7'h01;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 112;

    // result tdata bit positions
    localparam int O_TX_VALID = 0;
    localparam int O_TX_ADDR  = 1;
    localparam int O_TX_LEN   = 33;
    localparam int O_DROPPED  = 40;

    typedef enum logic [1:0] {
        KIND_SUBMIT   = 2'd0,
        KIND_POLL     = 2'd1,
        KIND_COMPLETE = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] seg_addr;
        logic [31:0] seg_len;
        logic        configured;
        logic [7:0]  endpoint;
    } item_t;

    typedef struct packed {
        logic                tx_valid;
        logic [31:0]         tx_addr;
        logic [TX_LEN_W-1:0] tx_len;
        logic                dropped;
        logic [31:0]         drop_total;
        logic [31:0]         queued_total;
        logic [PEND_W-1:0]   pending_segments;
    } result_t;

endpackage

[design/sqp_ram.sv]
module sqp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[design/sqp_ring.sv]
module sqp_ring #(
    parameter int RING_DEPTH   = sqp_pkg::RING_DEPTH_DEF,
    parameter int PACKET_BYTES = sqp_pkg::PACKET_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  sqp_pkg::item_t   item,
    output sqp_pkg::result_t res
);

    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam logic [31:0] PKT = 32'(PACKET_BYTES);

    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0] send_slot_reg, send_slot_next;
    logic [31:0]       head_off_reg, head_off_next;
    logic [31:0]       drop_cnt_reg, drop_cnt_next;
    logic [31:0]       byte_cnt_reg, byte_cnt_next;

    logic              byp_a_reg, byp_b_reg;
    logic [63:0]       byp_data_reg;

    logic              ram_we;
    logic [SLOT_W-1:0] rd_a, rd_b;
    logic [63:0]       ram_a, ram_b, view_a, view_b;

    logic              empty, full, pop, new_empty;
    logic [SLOT_W-1:0] write_inc;
    logic [31:0]       rem, step;
    logic              try_tx;
    logic              drop_flag;
    logic [31:0]       sel_addr, sel_len, sel_off, rem2, step2;
    logic [31:0]       pend32;

    function automatic logic [SLOT_W-1:0] inc_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    // view_a holds the head entry, view_b the one after it
    assign view_a = byp_a_reg ? byp_data_reg : ram_a;
    assign view_b = byp_b_reg ? byp_data_reg : ram_b;

    assign empty     = (write_slot_reg == send_slot_reg);
    assign write_inc = inc_slot(write_slot_reg);
    assign full      = (write_inc == send_slot_reg);

    assign rem  = view_a[31:0] - head_off_reg;
    assign step = (rem > PKT) ? PKT : rem;
    assign pop  = (rem == step);

    always_comb begin
        write_slot_next = write_slot_reg;
        send_slot_next  = send_slot_reg;
        head_off_next   = head_off_reg;
        drop_cnt_next   = drop_cnt_reg;
        byte_cnt_next   = byte_cnt_reg;
        ram_we          = 1'b0;
        drop_flag       = 1'b0;
        try_tx          = 1'b0;
        new_empty       = empty;
        sel_addr        = view_a[63:32];
        sel_len         = view_a[31:0];
        sel_off         = head_off_reg;
        case (item.kind)
            sqp_pkg::KIND_SUBMIT: begin
                if (item.seg_len != 32'd0) begin
                    if (full) begin
                        drop_cnt_next = drop_cnt_reg + 32'd1;
                        drop_flag     = 1'b1;
                    end else begin
                        ram_we          = 1'b1;
                        write_slot_next = write_inc;
                        byte_cnt_next   = byte_cnt_reg + item.seg_len;
                    end
                end
            end
            sqp_pkg::KIND_POLL: begin
                try_tx = item.configured;
            end
            sqp_pkg::KIND_COMPLETE: begin
                if ((item.endpoint[6:0] & sqp_pkg::EP_NUM_MASK) == sqp_pkg::EP_TX) begin
                    try_tx = item.configured;
                    if (!empty) begin
                        if (pop) begin
                            send_slot_next = inc_slot(send_slot_reg);
                            head_off_next  = 32'd0;
                            new_empty      = (write_slot_reg == inc_slot(send_slot_reg));
                            sel_addr       = view_b[63:32];
                            sel_len        = view_b[31:0];
                            sel_off        = 32'd0;
                        end else begin
                            head_off_next = head_off_reg + step;
                            sel_off       = head_off_reg + step;
                        end
                    end
                end
            end
            default: begin
                try_tx = 1'b0;
            end
        endcase
    end

    assign rem2  = sel_len - sel_off;
    assign step2 = (rem2 > PKT) ? PKT : rem2;

    assign pend32 = 32'(write_slot_next) - 32'(send_slot_next)
                  + ((write_slot_next < send_slot_next) ? 32'(RING_DEPTH) : 32'd0);

    always_comb begin
        res.tx_valid = try_tx && !new_empty && (rem2 != 32'd0);
        res.tx_addr  = res.tx_valid ? (sel_addr + sel_off) : 32'd0;
        res.tx_len   = res.tx_valid ? step2[sqp_pkg::TX_LEN_W-1:0] : '0;
        res.dropped          = drop_flag;
        res.drop_total       = drop_cnt_next;
        res.queued_total     = byte_cnt_next;
        res.pending_segments = pend32[sqp_pkg::PEND_W-1:0];
    end

    // read the slots that are head and head plus one after this edge
    assign rd_a = fire ? send_slot_next : send_slot_reg;
    assign rd_b = inc_slot(rd_a);

    sqp_ram #(
        .WIDTH (64),
        .DEPTH (RING_DEPTH)
    ) u_sqp_ram (
        .clk     (aclk),
        .we      (fire && ram_we),
        .waddr   (write_slot_reg),
        .wdata   ({item.seg_addr, item.seg_len}),
        .raddr_a (rd_a),
        .rdata_a (ram_a),
        .raddr_b (rd_b),
        .rdata_b (ram_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_slot_reg <= '0;
            send_slot_reg  <= '0;
            head_off_reg   <= '0;
            drop_cnt_reg   <= '0;
            byte_cnt_reg   <= '0;
            byp_a_reg      <= 1'b0;
            byp_b_reg      <= 1'b0;
        end else begin
            if (fire) begin
                write_slot_reg <= write_slot_next;
                send_slot_reg  <= send_slot_next;
                head_off_reg   <= head_off_next;
                drop_cnt_reg   <= drop_cnt_next;
                byte_cnt_reg   <= byte_cnt_next;
            end
            byp_a_reg <= fire && ram_we && (write_slot_reg == rd_a);
            byp_b_reg <= fire && ram_we && (write_slot_reg == rd_b);
        end
    end

    always_ff @(posedge aclk) begin
        byp_data_reg <= {item.seg_addr, item.seg_len};
    end

endmodule

[design/segment_queue_packetizer.sv]
// Segment queue packetizer: submit items push (address, length) segments into a ring of
// RING_DEPTH slots that holds at most RING_DEPTH-1 segments; poll and endpoint-1 completion
// items cut the head segment into transmit commands of at most PACKET_BYTES bytes. Every
// input item yields exactly one result item. One item is taken per clock cycle unless
// m_tready stalls the output; items pass the input register, then the result register; the
// ring is a RAM with two registered read ports that always present the head and next slots.
module segment_queue_packetizer #(
    parameter int RING_DEPTH   = sqp_pkg::RING_DEPTH_DEF,
    parameter int PACKET_BYTES = sqp_pkg::PACKET_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // seg_addr, seg_len, configured, endpoint, zero pad
    input  logic [sqp_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tx_valid, tx_addr, tx_len, dropped, drop_total, queued_total, pending_segments, zero pad
    output logic [sqp_pkg::M_TDATA_W-1:0] m_tdata
);

    logic             in_vld_reg;
    sqp_pkg::item_t   in_item_reg;
    logic             out_vld_reg;
    sqp_pkg::result_t out_res_reg;
    logic             advance;
    sqp_pkg::result_t ring_res;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.kind       <= sqp_pkg::kind_t'(s_tuser);
            in_item_reg.seg_addr   <= s_tdata[31:0];
            in_item_reg.seg_len    <= s_tdata[63:32];
            in_item_reg.configured <= s_tdata[64];
            in_item_reg.endpoint   <= s_tdata[72:65];
        end
        if (advance) begin
            out_res_reg <= ring_res;
        end
    end

    sqp_ring #(
        .RING_DEPTH   (RING_DEPTH),
        .PACKET_BYTES (PACKET_BYTES)
    ) u_sqp_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (in_item_reg),
        .res     (ring_res)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'd0,
                       out_res_reg.pending_segments,
                       out_res_reg.queued_total,
                       out_res_reg.drop_total,
                       out_res_reg.dropped,
                       out_res_reg.tx_len,
                       out_res_reg.tx_addr,
                       out_res_reg.tx_valid};

endmodule

[design/sqp_checker.sv]
`include "segment_queue_packetizer_defines.svh"

module sqp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sqp_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                         tx_v;
    logic                         drop_v;
    logic [31:0]                  tx_a;
    logic [sqp_pkg::TX_LEN_W-1:0] tx_l;

    assign tx_v   = m_tdata[sqp_pkg::O_TX_VALID];
    assign drop_v = m_tdata[sqp_pkg::O_DROPPED];
    assign tx_a   = m_tdata[sqp_pkg::O_TX_ADDR +: 32];
    assign tx_l   = m_tdata[sqp_pkg::O_TX_LEN +: sqp_pkg::TX_LEN_W];

    `SQP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result item dropped while stalled")
    `SQP_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid, "result item valid after reset")
    `SQP_ASSERT(a_no_tx_zero, m_tvalid && !tx_v |-> (tx_a == 32'd0) && (tx_l == '0), "idle data")
    `SQP_ASSERT(a_drop_no_tx, m_tvalid && drop_v |-> !tx_v, "dropped submission issued a transmit")

endmodule

bind segment_queue_packetizer sqp_checker u_sqp_checker (.*);
